// ===== sv/clcb_pkg.sv =====
// ----------------------------------------------------------------------------
// clcb_pkg: shared definitions for the character display cursor buffer
// Holds the default geometry, the field widths and the control and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package clcb_pkg;

    // Default number of character columns in each of the two rows.
    localparam int CLCB_NUM_COLS = 16;

    // Field widths of the stream and configuration ports.
    localparam int OP_W      = 4;
    localparam int CHAR_W    = 8;
    localparam int NROW_W    = 2;
    localparam int NCOL_W    = 5;
    localparam int THR_W     = 7;
    localparam int OUT_COL_W = 4;
    localparam int S_DATA_W  = 16;
    localparam int S_USER_W  = 4;
    localparam int M_DATA_W  = 16;

    // Reset value of the character threshold register.
    localparam logic [THR_W-1:0] THR_RESET = 7'd31;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;  // capture the accepted input transaction
        logic exec;      // carry out the latched command
        logic load_out;  // load the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;   // latched command reads the cell store
    } t_status;

endpackage

// ===== sv/char_lcd_cursor_buffer_core.sv =====
// ----------------------------------------------------------------------------
// char_lcd_cursor_buffer_core: two-row character store with a cursor
// Commands arrive on the slave stream (command code in tuser, character and
// target position in tdata). Each command produces one result transaction
// on the master stream with the status, the cursor, the sticky movement
// error and, for a read, the cell at the cursor.
//
// The result is loaded into the output register after the execute step, or
// after execute and a read wait step for a read, because the cell memory has a
// registered read port. The slave side is ready again once the result is
// loaded, so the next command is accepted only after the last one has been
// loaded into the output register.
// If the receiver stalls, the result waits in the output register and the
// next command is still accepted and executed; it then holds in the load
// step until the output register drains.
// Reset is synchronous, active low: it clears the cursor, the error flag
// and all cell valid bits at once (every cell reads zero), sets the threshold
// register to 31. Clear also invalidates all cells at once. The user writes
// the threshold via the configuration port only while idle (not enforced).
// ----------------------------------------------------------------------------
module char_lcd_cursor_buffer_core
    import clcb_pkg::*;
#(
    parameter int NUM_COLS = CLCB_NUM_COLS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // tdata fields from bit 0: char_code[7:0], new_row[9:8], new_col[14:10]
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // tuser fields from bit 0: op[3:0]
    input  logic [S_USER_W-1:0] i_s_tuser,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // tdata fields from bit 0: ok[0], cursor_row[1], cursor_col[5:2],
    // move_error[6], read_data[14:7]
    output logic [M_DATA_W-1:0] o_m_tdata,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    input  logic                i_cfg_wr_en,
    input  logic [THR_W-1:0]    i_cfg_wr_data
);

    t_cmd    cmd;
    t_status status;

    // Command sequencer.
    clcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Store, cursor and result registers.
    clcb_datapath #(
        .NUM_COLS (NUM_COLS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_m_tdata     (o_m_tdata)
    );

`ifndef ASSERT_OFF
    // Only one command is in flight: acceptance closes the slave side.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("slave side accepted a second command while busy");

    // Nonzero read data only comes from a read, which always succeeds.
    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[14:7] != 8'd0)) |-> o_m_tdata[0])
        else $error("read data reported on a failed command");

    // The reported cursor column stays inside the display.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ({3'b000, o_m_tdata[5:2]} < 7'(NUM_COLS)))
        else $error("cursor column out of range");
`endif

endmodule

// ===== sv/clcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// clcb_ctrl: command sequencer
// Steps each accepted transaction through execute, an optional memory read
// wait, and the hand-off into the output register.
// ----------------------------------------------------------------------------
module clcb_ctrl
    import clcb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_s_tready;
    logic   r_m_tvalid;
    logic   out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !r_m_tvalid || i_m_tready;

    // Commands decoded from the current state.
    always_comb begin
        o_cmd          = '0;
        o_cmd.latch_in = (r_state == S_IDLE) && r_s_tready && i_s_tvalid;
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.load_out = (r_state == S_EMIT) && out_free;
    end

    // State register and registered handshake outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_s_tready <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.latch_in) begin
                        r_state    <= S_EXEC;
                        r_s_tready <= 1'b0;
                    end else begin
                        r_s_tready <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state <= i_status.is_read ? S_RDWAIT : S_EMIT;
                end
                S_RDWAIT: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state    <= S_IDLE;
                        r_s_tready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_s_tready <= 1'b0;
                end
            endcase
        end
    end

    assign o_s_tready = r_s_tready;
    assign o_m_tvalid = r_m_tvalid;

endmodule

// ===== sv/clcb_datapath.sv =====
// ----------------------------------------------------------------------------
// clcb_datapath: cell store, cursor and result registers
// Holds the character memory with per-cell valid bits, the cursor, the
// sticky movement error, the threshold register and the output register.
// ----------------------------------------------------------------------------
module clcb_datapath
    import clcb_pkg::*;
#(
    parameter int NUM_COLS = CLCB_NUM_COLS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [S_DATA_W-1:0] i_s_tdata,
    input  logic [S_USER_W-1:0] i_s_tuser,
    input  logic                i_cfg_wr_en,
    input  logic [THR_W-1:0]    i_cfg_wr_data,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    output logic [M_DATA_W-1:0] o_m_tdata
);

    localparam int CW    = $clog2(NUM_COLS);
    localparam int AW    = CW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam logic [CW-1:0] LAST_COL = CW'(NUM_COLS - 1);

    // Command codes carried in the input user field.
    localparam logic [OP_W-1:0] OP_WRITE     = 4'd0;
    localparam logic [OP_W-1:0] OP_CLEAR     = 4'd1;
    localparam logic [OP_W-1:0] OP_CLEAR_EOL = 4'd2;
    localparam logic [OP_W-1:0] OP_UP        = 4'd3;
    localparam logic [OP_W-1:0] OP_DOWN      = 4'd4;
    localparam logic [OP_W-1:0] OP_RIGHT     = 4'd5;
    localparam logic [OP_W-1:0] OP_LEFT      = 4'd6;
    localparam logic [OP_W-1:0] OP_SET_POS   = 4'd7;
    localparam logic [OP_W-1:0] OP_READ      = 4'd8;

    // Latched input transaction.
    logic [OP_W-1:0]     r_op;
    logic [CHAR_W-1:0]   r_code;
    logic [NROW_W-1:0]   r_nrow;
    logic [NCOL_W-1:0]   r_ncol;

    // Architectural state.
    logic [THR_W-1:0]    r_thr;
    logic                r_row, n_row;
    logic [CW-1:0]       r_col, n_col;
    logic                r_err, n_err;
    logic                r_ok, n_ok;
    logic [DEPTH-1:0]    r_valid, n_valid;
    logic [CHAR_W-1:0]   r_mem [DEPTH];
    logic [CHAR_W-1:0]   r_rd_data;
    logic                r_rd_valid;
    logic [M_DATA_W-1:0] r_out;

    logic [AW-1:0]       addr;
    logic                wr_en;
    logic                char_pass;
    logic                right_ok, right_row;
    logic [CW-1:0]       right_col;
    logic                left_ok, left_row;
    logic [CW-1:0]       left_col;
    logic                pos_ok;
    logic [CHAR_W-1:0]   rdata;

    assign addr      = {r_row, r_col};
    assign o_status.is_read = (r_op == OP_READ);

    // A character passes when it is non-negative and above the threshold.
    assign char_pass = !r_code[CHAR_W-1] && (r_code[CHAR_W-2:0] > r_thr);

    // Cursor step right, wrapping from the end of row 0 into row 1.
    assign right_ok  = (r_col != LAST_COL) || !r_row;
    assign right_row = (r_col == LAST_COL) ? 1'b1 : r_row;
    assign right_col = (r_col != LAST_COL) ? r_col + CW'(1) : '0;

    // Cursor step left, wrapping from the start of row 1 into row 0.
    assign left_ok   = (r_col != '0) || r_row;
    assign left_row  = (r_col == '0) ? 1'b0 : r_row;
    assign left_col  = (r_col != '0) ? r_col - CW'(1) : LAST_COL;

    // A set position target must lie inside the display.
    assign pos_ok = !r_nrow[1] && ({2'b00, r_ncol} < 7'(NUM_COLS));

    // Next-state logic for one command.
    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_err   = r_err;
        n_ok    = 1'b0;
        n_valid = r_valid;
        wr_en   = 1'b0;
        case (r_op)
            OP_WRITE: begin
                if (char_pass) begin
                    wr_en         = 1'b1;
                    n_valid[addr] = 1'b1;
                    n_ok          = right_ok;
                    if (right_ok) begin
                        n_row = right_row;
                        n_col = right_col;
                    end else begin
                        n_err = 1'b1;
                    end
                end
            end
            OP_CLEAR: begin
                n_valid = '0;
                n_row   = 1'b0;
                n_col   = '0;
                n_ok    = 1'b1;
            end
            OP_CLEAR_EOL: begin
                for (int i = 0; i < NUM_COLS; i++) begin
                    if (CW'(i) >= r_col) begin
                        n_valid[{r_row, CW'(i)}] = 1'b0;
                    end
                end
                n_ok = 1'b1;
            end
            OP_UP: begin
                n_ok = r_row;
                if (r_row) begin
                    n_row = 1'b0;
                end else begin
                    n_err = 1'b1;
                end
            end
            OP_DOWN: begin
                n_ok = !r_row;
                if (!r_row) begin
                    n_row = 1'b1;
                end else begin
                    n_err = 1'b1;
                end
            end
            OP_RIGHT: begin
                n_ok = right_ok;
                if (right_ok) begin
                    n_row = right_row;
                    n_col = right_col;
                end else begin
                    n_err = 1'b1;
                end
            end
            OP_LEFT: begin
                n_ok = left_ok;
                if (left_ok) begin
                    n_row = left_row;
                    n_col = left_col;
                end else begin
                    n_err = 1'b1;
                end
            end
            OP_SET_POS: begin
                if (pos_ok) begin
                    n_row = r_nrow[0];
                    n_col = CW'(r_ncol);
                    n_ok  = 1'b1;
                end
            end
            OP_READ: begin
                n_ok = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control state: cursor, error flag, valid bits and threshold.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_RESET;
            r_row   <= 1'b0;
            r_col   <= '0;
            r_err   <= 1'b0;
            r_valid <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            if (i_cmd.exec) begin
                r_row   <= n_row;
                r_col   <= n_col;
                r_err   <= n_err;
                r_valid <= n_valid;
            end
        end
    end

    // Input capture and command outcome.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_code <= i_s_tdata[7:0];
            r_nrow <= i_s_tdata[9:8];
            r_ncol <= i_s_tdata[14:10];
            r_op   <= i_s_tuser;
        end
        if (i_cmd.exec) begin
            r_ok <= n_ok;
        end
    end

    // Cell memory: one write port, one registered read port at the cursor.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[addr] <= r_code;
        end
        r_rd_data  <= r_mem[addr];
        r_rd_valid <= r_valid[addr];
    end

    // A cell never written since the last clear reads as zero.
    assign rdata = (o_status.is_read && r_rd_valid) ? r_rd_data : '0;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= {1'b0, rdata, r_err, OUT_COL_W'(r_col), r_row, r_ok};
        end
    end

    assign o_m_tdata = r_out;

endmodule
